// ----- hw/rtl/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package salc_pkg;

	localparam int ADDR_W      = 48;
	localparam int TAG_W       = ADDR_W - 2;   // shift is never less than two bits
	localparam int CNT_W       = 32;
	localparam int SB_W        = 3;
	localparam int WU_W        = 4;
	localparam int BB_W        = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int SET_RAW_W   = 6;             // widest set index in use
	localparam int SETS_IN_USE = 1 << SET_RAW_W;

	localparam int DEF_MAX_SETS = 64;
	localparam int DEF_MAX_WAYS = 8;

	localparam logic [SB_W-1:0] SB_MIN   = 3'd1;
	localparam logic [SB_W-1:0] SB_MAX   = 3'd6;
	localparam logic [SB_W-1:0] SB_RESET = 3'd4;
	localparam logic [WU_W-1:0] WU_RESET = 4'd1;
	localparam logic [BB_W-1:0] BB_MIN   = 5'd1;
	localparam logic [BB_W-1:0] BB_MAX   = 5'd16;
	localparam logic [BB_W-1:0] BB_RESET = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_WAYS_USED  = 2'd1,
		CFG_BLOCK_BITS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
	} in_t;

	typedef struct packed {
		logic             first_hit;
		logic             evicted;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] evict_total;
	} out_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic decide;
		logic commit;
	} cmd_t;

endpackage

// ----- hw/rtl/salc_ctrl.sv -----
// Sequencer for the cache: capture, set read, decision, writeback.
// Depends on salc_pkg; drives the command struct into salc_dp.
`timescale 1ns / 1ps

module salc_ctrl import salc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				// hold until the output register is free or being emptied
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/salc_dp.sv -----
// Cache datapath: config registers, set/tag extraction, set memory,
// hit/fill/victim decision, LRU rank update, totals and result register.
// Depends on salc_pkg; sequenced by salc_ctrl.
`timescale 1ns / 1ps

module salc_dp import salc_pkg::*; #(
	parameter int MAX_SETS = DEF_MAX_SETS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  in_t                   in_data,
	input  cmd_t                  cmd,
	output out_t                  out_data
);

	localparam int SET_W  = $clog2(MAX_SETS);
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	// configuration
	logic [SB_W-1:0] set_bits_q;
	logic [WU_W-1:0] ways_used_q;
	logic [BB_W-1:0] block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SB_RESET;
			ways_used_q  <= WU_RESET;
			block_bits_q <= BB_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SET_BITS:   set_bits_q   <= cfg_wr_data[SB_W-1:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_wr_data[WU_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_wr_data[BB_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SB_W-1:0] sb;
	logic [WU_W-1:0] nw;
	logic [BB_W-1:0] bb;

	always_comb begin
		sb = (set_bits_q < SB_MIN) ? SB_MIN : (set_bits_q > SB_MAX) ? SB_MAX : set_bits_q;
		bb = (block_bits_q < BB_MIN) ? BB_MIN :
			(block_bits_q > BB_MAX) ? BB_MAX : block_bits_q;
		if (ways_used_q == '0) begin
			nw = WU_W'(1);
		end else if (int'(ways_used_q) > MAX_WAYS) begin
			nw = WU_W'(MAX_WAYS);
		end else begin
			nw = ways_used_q;
		end
	end

	// set index and tag of the incoming request
	logic [ADDR_W-1:0]    addr_sh;
	logic [BB_W:0]        tag_shift;
	logic [ADDR_W-1:0]    tag_full;
	logic [SET_RAW_W:0]   set_one;
	logic [SET_RAW_W-1:0] set_raw;
	logic [SET_W-1:0]     set_idx;

	always_comb begin
		addr_sh   = in_data.address >> bb;
		set_one   = (SET_RAW_W+1)'(1) << sb;
		set_raw   = addr_sh[SET_RAW_W-1:0] & SET_RAW_W'(set_one - 1'b1);
		tag_shift = (BB_W+1)'(sb) + (BB_W+1)'(bb);
		tag_full  = in_data.address >> tag_shift;
	end

	// set index wraps onto the sets actually built
	if (MAX_SETS >= SETS_IN_USE) begin : g_set_direct
		assign set_idx = SET_W'(set_raw);
	end else begin : g_set_wrap
		logic [SET_RAW_W-1:0] rem;
		always_comb begin
			rem = set_raw;
			for (int k = SET_RAW_W - 1; k >= 0; k--) begin
				if (32'(rem) >= (32'(MAX_SETS) << k)) begin
					rem = rem - SET_RAW_W'(32'(MAX_SETS) << k);
				end
			end
		end
		assign set_idx = SET_W'(rem);
	end

	logic             kind_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_data.kind;
			set_q  <= set_idx;
			tag_q  <= tag_full[TAG_W-1:0];
		end
	end

	// set memory: one row holds every way of a set
	logic [MAX_WAYS-1:0]             mem_vld  [MAX_SETS];
	logic [MAX_WAYS-1:0][TAG_W-1:0]  mem_tag  [MAX_SETS];
	logic [MAX_WAYS-1:0][RANK_W-1:0] mem_rank [MAX_SETS];

	logic [MAX_WAYS-1:0]             rd_vld_q;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag_q;
	logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank_q;

	logic [MAX_WAYS-1:0]             dec_vld_q;
	logic [MAX_WAYS-1:0][RANK_W-1:0] dec_rank_q;
	logic [WAY_W-1:0]                dec_way_q;
	logic                            dec_hit_q;
	logic                            dec_evict_q;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  wr_tag;

	always_comb begin
		wr_tag            = rd_tag_q;
		wr_tag[dec_way_q] = tag_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem_vld[set_q]  <= dec_vld_q;
			mem_tag[set_q]  <= wr_tag;
			mem_rank[set_q] <= dec_rank_q;
		end
		if (cmd.read) begin
			rd_vld_q  <= mem_vld[set_q];
			rd_tag_q  <= mem_tag[set_q];
			rd_rank_q <= mem_rank[set_q];
		end
	end

	// a row never written reads as all lines invalid
	logic [MAX_SETS-1:0] row_ok_q;
	logic                rd_row_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q    <= '0;
			rd_row_ok_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				row_ok_q[set_q] <= 1'b1;
			end
			if (cmd.read) begin
				rd_row_ok_q <= row_ok_q[set_q];
			end
		end
	end

	// decision: hit, first free way, or oldest way
	logic [MAX_WAYS-1:0]             vld, in_use, match;
	logic                            hit, has_free, no_limit;
	logic [WAY_W-1:0]                hit_way, free_way, victim, sel_way;
	logic [RANK_W-1:0]               vrank, limit;
	logic [MAX_WAYS-1:0]             new_vld;
	logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;

	always_comb begin
		vld = rd_vld_q & {MAX_WAYS{rd_row_ok_q}};
		for (int k = 0; k < MAX_WAYS; k++) begin
			in_use[k] = (k < int'(nw));
			match[k]  = in_use[k] && vld[k] && (rd_tag_q[k] == tag_q);
		end
	end

	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		has_free = 1'b0;
		free_way = '0;
		// walk downwards so the lowest way wins
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(k);
			end
			if (in_use[k] && !vld[k]) begin
				has_free = 1'b1;
				free_way = WAY_W'(k);
			end
		end
		vrank  = rd_rank_q[0];
		victim = '0;
		for (int k = 1; k < MAX_WAYS; k++) begin
			if (in_use[k] && (rd_rank_q[k] > vrank)) begin
				vrank  = rd_rank_q[k];
				victim = WAY_W'(k);
			end
		end
	end

	always_comb begin
		if (hit) begin
			sel_way  = hit_way;
			limit    = rd_rank_q[hit_way];
			no_limit = 1'b0;
		end else if (has_free) begin
			sel_way  = free_way;
			limit    = vrank;
			no_limit = 1'b1;
		end else begin
			sel_way  = victim;
			limit    = vrank;
			no_limit = 1'b0;
		end
		new_vld  = vld;
		new_rank = rd_rank_q;
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (WAY_W'(k) == sel_way) begin
				new_vld[k]  = 1'b1;
				new_rank[k] = '0;
			end else if (in_use[k] && vld[k] && (no_limit || rd_rank_q[k] < limit)
					&& rd_rank_q[k] < RANK_MAX) begin
				new_rank[k] = rd_rank_q[k] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			dec_vld_q   <= new_vld;
			dec_rank_q  <= new_rank;
			dec_way_q   <= sel_way;
			dec_hit_q   <= hit;
			dec_evict_q <= !hit && !has_free;
		end
	end

	// running totals; the second access of a modify always hits
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [CNT_W-1:0] hit_next, miss_next, evict_next;
	logic [CNT_W:0]   hit_sum, miss_sum, evict_sum;
	logic [1:0]       hit_inc;

	always_comb begin
		hit_inc    = {1'b0, dec_hit_q} + {1'b0, kind_q};
		hit_sum    = {1'b0, hit_cnt_q} + (CNT_W+1)'(hit_inc);
		miss_sum   = {1'b0, miss_cnt_q} + (CNT_W+1)'(!dec_hit_q);
		evict_sum  = {1'b0, evict_cnt_q} + (CNT_W+1)'(dec_evict_q);
		hit_next   = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
		miss_next  = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
		evict_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.commit) begin
			hit_cnt_q   <= hit_next;
			miss_cnt_q  <= miss_next;
			evict_cnt_q <= evict_next;
		end
	end

	out_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.first_hit   <= dec_hit_q;
			out_q.evicted     <= dec_evict_q;
			out_q.hit_total   <= hit_next;
			out_q.miss_total  <= miss_next;
			out_q.evict_total <= evict_next;
		end
	end

	assign out_data = out_q;

endmodule

// ----- hw/rtl/set_assoc_lru_cache_model.sv -----
// Set-associative cache model with LRU replacement. Each request is a single
// access or a modify (two accesses to one address) and yields one result with
// the first access's hit/eviction flags and saturating hit, miss and eviction
// totals. Set and tag are captured at the accepting edge, and the result is
// loaded after a registered read of the whole set row, the way compare and
// victim search, and the row writeback, in that order. Requests are handled
// one at a time; the next one is accepted only once the result is loaded, and
// the writeback waits while a previous result is still held in the output
// register. The modify's second access hits by construction and only adds to
// the hit total.
// Depends on salc_pkg, salc_ctrl and salc_dp.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model import salc_pkg::*; #(
	parameter int MAX_SETS = DEF_MAX_SETS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data
);

	cmd_t cmd;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	salc_dp #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.out_data    (out_data)
	);

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for set_assoc_lru_cache_model: directed and random requests
// against an in-bench LRU predictor, with random sender gaps and receiver stalls.
// Depends on salc_pkg and the set_assoc_lru_cache_model RTL.
`timescale 1ns / 1ps

module testbench;
	import salc_pkg::*;

	localparam int LINES      = DEF_MAX_SETS * DEF_MAX_WAYS;
	localparam int CYCLE_CAP  = 400000;
	localparam int DRAIN_WAIT = 8;

	class lru_scoreboard;
		logic [SB_W-1:0]  set_bits_q;
		logic [WU_W-1:0]  ways_q;
		logic [BB_W-1:0]  block_bits_q;
		bit               line_ok[LINES];
		logic [TAG_W-1:0] line_tag[LINES];
		logic [2:0]       line_age[LINES];
		logic [CNT_W-1:0] hits, misses, evicts;
		out_t             pending_outcomes[$];
		int               fails, checked, requests, modifies;

		function new();
			set_bits_q   = SB_RESET;
			ways_q       = WU_RESET;
			block_bits_q = BB_RESET;
			foreach (line_ok[i]) begin
				line_ok[i]  = 1'b0;
				line_tag[i] = '0;
				line_age[i] = '0;
			end
			hits = '0;
			misses = '0;
			evicts = '0;
		endfunction

		function void report(string msg);
			fails++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SET_BITS:   set_bits_q = val[SB_W-1:0];
				CFG_WAYS_USED:  ways_q = val[WU_W-1:0];
				CFG_BLOCK_BITS: block_bits_q = val[BB_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		// way w becomes most recent; valid lines younger than lim get older
		function void make_recent(int base, int nw, int w, int lim);
			for (int k = 0; k < nw; k++) begin
				if (k != w && line_ok[base + k] && line_age[base + k] < lim &&
						line_age[base + k] < DEF_MAX_WAYS - 1)
					line_age[base + k]++;
			end
			line_age[base + w] = '0;
		endfunction

		function bit lookup_line(logic [ADDR_W-1:0] addr, output bit ev);
			int sb, nw, bb, base, victim, vrank;
			logic [ADDR_W-1:0] set_idx;
			logic [TAG_W-1:0]  tg;
			sb = set_bits_q;
			nw = ways_q;
			bb = block_bits_q;
			if (sb < SB_MIN) sb = SB_MIN;
			if (sb > SB_MAX) sb = SB_MAX;
			if (nw < 1) nw = 1;
			if (nw > DEF_MAX_WAYS) nw = DEF_MAX_WAYS;
			if (bb < BB_MIN) bb = BB_MIN;
			if (bb > BB_MAX) bb = BB_MAX;
			set_idx = (addr >> bb) & ((ADDR_W'(1) << sb) - 1);
			tg      = TAG_W'(addr >> (sb + bb));
			base    = int'(set_idx % DEF_MAX_SETS) * DEF_MAX_WAYS;
			ev      = 1'b0;
			victim  = 0;
			vrank   = 0;
			for (int k = 0; k < nw; k++) begin
				if (line_ok[base + k] && line_tag[base + k] == tg) begin
					hits = sat_inc(hits);
					make_recent(base, nw, k, line_age[base + k]);
					return 1'b1;
				end
			end
			misses = sat_inc(misses);
			for (int k = 0; k < nw; k++) begin
				if (!line_ok[base + k]) begin
					line_ok[base + k]  = 1'b1;
					line_tag[base + k] = tg;
					make_recent(base, nw, k, DEF_MAX_WAYS);
					return 1'b0;
				end
			end
			// set full: oldest rank goes, lowest way wins a tie
			for (int k = 0; k < nw; k++) begin
				if (k == 0 || line_age[base + k] > vrank) begin
					vrank  = line_age[base + k];
					victim = k;
				end
			end
			line_tag[base + victim] = tg;
			make_recent(base, nw, victim, vrank);
			evicts = sat_inc(evicts);
			ev = 1'b1;
			return 1'b0;
		endfunction

		function void note_request(in_t req);
			out_t exp_out;
			bit   ev, ev2, hit;
			hit = lookup_line(req.address, ev);
			if (req.kind) begin
				void'(lookup_line(req.address, ev2));
				modifies++;
			end
			requests++;
			exp_out.first_hit   = hit;
			exp_out.evicted     = ev;
			exp_out.hit_total   = hits;
			exp_out.miss_total  = misses;
			exp_out.evict_total = evicts;
			pending_outcomes.push_back(exp_out);
		endfunction

		function void check_result(out_t got);
			out_t exp_out;
			if (pending_outcomes.size() == 0) begin
				report($sformatf("result with no request waiting: %h", got));
				return;
			end
			exp_out = pending_outcomes.pop_front();
			checked++;
			if (got.first_hit !== exp_out.first_hit)
				report($sformatf("result %0d first_hit %b, want %b",
					checked, got.first_hit, exp_out.first_hit));
			if (got.evicted !== exp_out.evicted)
				report($sformatf("result %0d evicted %b, want %b",
					checked, got.evicted, exp_out.evicted));
			if (got.hit_total !== exp_out.hit_total)
				report($sformatf("result %0d hit_total %0d, want %0d",
					checked, got.hit_total, exp_out.hit_total));
			if (got.miss_total !== exp_out.miss_total)
				report($sformatf("result %0d miss_total %0d, want %0d",
					checked, got.miss_total, exp_out.miss_total));
			if (got.evict_total !== exp_out.evict_total)
				report($sformatf("result %0d evict_total %0d, want %0d",
					checked, got.evict_total, exp_out.evict_total));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;

	lru_scoreboard     sb;
	int                cycles;
	int                settings;
	int                burst_left;
	int                cur_sb, cur_wu, cur_bb;
	logic [ADDR_W-1:0] tag_pool[16];

	set_assoc_lru_cache_model u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// receiver stall: runs of none, light, heavy or alternating back-pressure
	initial begin
		int mode, len, tick;
		out_stall = 1'b0;
		tick = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(8, 80);
			repeat (len) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= tick[0];
				endcase
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("set_assoc_lru_cache_model verification failed");
		$finish;
	end

	task automatic send(in_t req);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(req);
	endtask

	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// drop valid and let every outstanding result come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= CFG_DATA_W'(val);
		@(posedge clk);
		sb.write_reg(idx, CFG_DATA_W'(val));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(int s, int w, int b);
		write_reg(CFG_SET_BITS, s);
		write_reg(CFG_WAYS_USED, w);
		write_reg(CFG_BLOCK_BITS, b);
		cur_sb = (s < SB_MIN) ? SB_MIN : (s > SB_MAX) ? SB_MAX : s;
		cur_wu = (w < 1) ? 1 : (w > DEF_MAX_WAYS) ? DEF_MAX_WAYS : w;
		cur_bb = (b < BB_MIN) ? BB_MIN : (b > BB_MAX) ? BB_MAX : b;
		settings++;
	endtask

	task automatic refresh_tags();
		foreach (tag_pool[i])
			tag_pool[i] = (i < 4) ? ADDR_W'(i) : ADDR_W'({$urandom, $urandom});
	endtask

	function automatic logic [ADDR_W-1:0] compose(logic [ADDR_W-1:0] tg, int set_i, int off);
		logic [63:0] a;
		a = (64'(tg) << (cur_sb + cur_bb)) | (64'(set_i) << cur_bb) | 64'(off);
		return a[ADDR_W-1:0];
	endfunction

	// mostly a small tag pool on a couple of sets so lines hit and get evicted
	function automatic in_t pick_request();
		in_t req;
		int  r, set_i, off;
		r = $urandom_range(0, 99);
		req.kind = ($urandom_range(0, 9) < 3);
		off = int'($urandom & ((32'd1 << cur_bb) - 1));
		set_i = (r < 60) ? $urandom_range(0, 1) : $urandom_range(0, (1 << cur_sb) - 1);
		if (r < 15)
			req.address = ADDR_W'({$urandom, $urandom});
		else
			req.address = compose(tag_pool[$urandom_range(0, cur_wu + 2)], set_i, off);
		return req;
	endfunction

	task automatic run_random(int count);
		int gap;
		repeat (count) begin
			send(pick_request());
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				                                          : $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				pause(gap);
			end
		end
	endtask

	initial begin
		in_t   req;
		int    phase_sb[9]  = '{1, 6, 0, 7, 2, 2, 2, 3, 5};
		int    phase_wu[9]  = '{8, 8, 0, 15, 4, 2, 8, 3, 6};
		int    phase_bb[9]  = '{1, 16, 0, 31, 5, 5, 5, 9, 13};
		int    phase_cnt[9] = '{200, 200, 150, 150, 200, 200, 200, 200, 150};
		logic [ADDR_W-1:0] reset_addrs[12] = '{
			48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_000F,
			48'h0000_0000_0100, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'h7FFF_FFFF_FFF0, 48'h0000_0000_0800, 48'h0000_0000_0000,
			48'h8000_0000_0000, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA};
		bit    reset_kind[12] = '{0, 0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1};

		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = CFG_SET_BITS;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		settings    = 1;
		burst_left  = 4;
		cur_sb      = SB_RESET;
		cur_wu      = WU_RESET;
		cur_bb      = BB_RESET;
		refresh_tags();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting, one way: fills, hits, evictions, modify, address extremes
		foreach (reset_addrs[i]) begin
			req.kind    = reset_kind[i];
			req.address = reset_addrs[i];
			send(req);
		end
		settle();

		// two sets of eight ways: fill set 0 in order, refresh way 0, then evict
		configure(1, 8, 1);
		for (int t = 0; t < 10; t++) begin
			req.kind    = (t == 9);
			req.address = compose(ADDR_W'((t == 8) ? 0 : (t == 9) ? 8 : t), 0, 0);
			send(req);
			if (t == 4)
				pause(3);
		end
		settle();

		// stored lines stay across setting changes
		for (int p = 0; p < 9; p++) begin
			configure(phase_sb[p], phase_wu[p], phase_bb[p]);
			if (p % 2 == 0)
				refresh_tags();
			run_random(phase_cnt[p]);
			settle();
		end

		if (sb.pending_outcomes.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_outcomes.size()));
		$display("covered %0d requests (%0d modify) across %0d register settings",
			sb.requests, sb.modifies, settings);
		$display("%0d results compared, %0d mismatches, %0d cycles",
			sb.checked, sb.fails, cycles);
		if (sb.fails == 0)
			$display("set_assoc_lru_cache_model verification clean");
		else
			$display("set_assoc_lru_cache_model verification failed");
		$finish;
	end

endmodule
